// ===== rtl/core/complex_arithmetic_unit_core_assert.svh =====
// Assertion macros for the complex arithmetic unit core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Assertion sampled on the clock, disabled while reset is asserted.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form, disabled while reset is asserted.
`define CAU_ASSERT_IMP(label, pre, post, msg) \
  `CAU_ASSERT(label, (pre) |-> (post), msg)

`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared types and defaults for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int unsigned DataWidthDefault = 16;
  localparam int unsigned FracBitsDefault  = 8;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cau_prod.sv =====
// Product and sum stages of the complex arithmetic unit (two register stages).
// Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_prod #(
  parameter int unsigned W = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  cau_pkg::ctrl_t             ctrl_i,
  input  wire logic signed [W-1:0]   a_re_i,
  input  wire logic signed [W-1:0]   a_im_i,
  input  wire logic signed [W-1:0]   b_re_i,
  input  wire logic signed [W-1:0]   b_im_i,
  output cau_pkg::ctrl_t             ctrl_o,
  output logic signed [2*W:0]        re_o,
  output logic signed [2*W:0]        im_o,
  output logic [2*W-1:0]             den_o
);
  import cau_pkg::*;

  ctrl_t ctrl1_q;
  logic signed [2*W-1:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;
  ctrl_t ctrl2_q;
  logic signed [2*W:0] re_d, im_d, re_q, im_q;
  logic [2*W-1:0] den_d, den_q;
  logic signed [2*W:0] s_ar, s_ai, s_br, s_bi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else if (en_i) begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q  <= a_re_i * b_re_i;
      bd_q  <= a_im_i * b_im_i;
      ad_q  <= a_re_i * b_im_i;
      bc_q  <= a_im_i * b_re_i;
      cc_q  <= b_re_i * b_re_i;
      dd_q  <= b_im_i * b_im_i;
      ar_q  <= a_re_i;
      ai_q  <= a_im_i;
      br_q  <= b_re_i;
      bi_q  <= b_im_i;
      re_q  <= re_d;
      im_q  <= im_d;
      den_q <= den_d;
    end
  end

  assign s_ar = (2*W+1)'(ar_q);
  assign s_ai = (2*W+1)'(ai_q);
  assign s_br = (2*W+1)'(br_q);
  assign s_bi = (2*W+1)'(bi_q);

  always_comb begin
    den_d = $unsigned(cc_q) + $unsigned(dd_q);
    case (ctrl1_q.op)
      OpAdd: begin
        re_d = s_ar + s_br;
        im_d = s_ai + s_bi;
      end
      OpSub: begin
        re_d = s_ar - s_br;
        im_d = s_ai - s_bi;
      end
      OpMul: begin
        re_d = (2*W+1)'(ac_q) - (2*W+1)'(bd_q);
        im_d = (2*W+1)'(ad_q) + (2*W+1)'(bc_q);
      end
      default: begin
        re_d = (2*W+1)'(ac_q) + (2*W+1)'(bd_q);
        im_d = (2*W+1)'(bc_q) - (2*W+1)'(ad_q);
      end
    endcase
  end

  assign ctrl_o = ctrl2_q;
  assign re_o   = re_q;
  assign im_o   = im_q;
  assign den_o  = den_q;

endmodule

`default_nettype wire

// ===== rtl/core/cau_div_step.sv =====
// One restoring division step for both result parts, with side data carried along.
// Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_step #(
  parameter int unsigned RW = 50,
  parameter int unsigned DW = 32,
  parameter int unsigned QB = 17,
  parameter int unsigned SH = 0,
  parameter int unsigned SW = 39
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  cau_pkg::ctrl_t      ctrl_i,
  input  wire logic [RW-1:0]  rem_re_i,
  input  wire logic [RW-1:0]  rem_im_i,
  input  wire logic [QB-1:0]  q_re_i,
  input  wire logic [QB-1:0]  q_im_i,
  input  wire logic [DW-1:0]  den_i,
  input  wire logic [SW-1:0]  side_i,
  output cau_pkg::ctrl_t      ctrl_o,
  output logic [RW-1:0]       rem_re_o,
  output logic [RW-1:0]       rem_im_o,
  output logic [QB-1:0]       q_re_o,
  output logic [QB-1:0]       q_im_o,
  output logic [DW-1:0]       den_o,
  output logic [SW-1:0]       side_o
);
  import cau_pkg::*;

  ctrl_t ctrl_q;
  logic [RW-1:0] trial;
  logic ge_re, ge_im;
  logic [RW-1:0] rem_re_d, rem_im_d, rem_re_q, rem_im_q;
  logic [QB-1:0] q_re_d, q_im_d, q_re_q, q_im_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] side_q;

  assign trial = RW'(den_i) << SH;

  always_comb begin
    ge_re    = rem_re_i >= trial;
    ge_im    = rem_im_i >= trial;
    rem_re_d = ge_re ? rem_re_i - trial : rem_re_i;
    rem_im_d = ge_im ? rem_im_i - trial : rem_im_i;
    q_re_d   = q_re_i;
    q_im_d   = q_im_i;
    q_re_d[SH] = ge_re;
    q_im_d[SH] = ge_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      q_re_q   <= q_re_d;
      q_im_q   <= q_im_d;
      den_q    <= den_i;
      side_q   <= side_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign q_re_o   = q_re_q;
  assign q_im_o   = q_im_q;
  assign den_o    = den_q;
  assign side_o   = side_q;

endmodule

`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit_core.sv =====
// Complex add, subtract, multiply and divide on signed fixed-point operands, saturating.
// Depends on cau_pkg, cau_prod, cau_div_step and complex_arithmetic_unit_core_assert.svh.
//
// The core is a fully pipelined datapath that accepts one transaction per cycle while the
// output is not stalled and returns one result per transaction, in order. Every transaction
// passes through the same stages whatever the operation: the product and sum registers, the
// rounding and divide setup register, DATA_WIDTH + 1 restoring divider steps of one quotient
// bit each, and the output register. A stalled output holds the whole pipeline; input ready
// is high whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDefault,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic signed [DATA_WIDTH-1:0]  a_re_i,
  input  wire logic signed [DATA_WIDTH-1:0]  a_im_i,
  input  wire logic signed [DATA_WIDTH-1:0]  b_re_i,
  input  wire logic signed [DATA_WIDTH-1:0]  b_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]       res_re_o,
  output logic signed [DATA_WIDTH-1:0]       res_im_o,
  output logic                               div_zero_o,
  output logic                               overflow_o
);
  import cau_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned VW = 2 * W + 1;
  localparam int unsigned QB = W + 1;
  localparam int unsigned RW = 3 * W + F + 2;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned SW = 2 * W + 7;

  localparam int unsigned PosIm   = 0;
  localparam int unsigned PosRe   = W;
  localparam int unsigned PosOvrI = 2 * W;
  localparam int unsigned PosOvrR = 2 * W + 1;
  localparam int unsigned PosNegI = 2 * W + 2;
  localparam int unsigned PosNegR = 2 * W + 3;
  localparam int unsigned PosOvf  = 2 * W + 4;
  localparam int unsigned PosDz   = 2 * W + 5;
  localparam int unsigned PosDiv  = 2 * W + 6;

  localparam logic signed [VW-1:0] SatMax = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SatMin = -SatMax - VW'(1);
  localparam logic [W-1:0] OutMax = W'(SatMax);
  localparam logic [W-1:0] OutMin = W'(SatMin);

  function automatic logic [W:0] sat_val(input logic signed [VW-1:0] x);
    logic [W:0] r;
    if (x > SatMax) begin
      r = {1'b1, OutMax};
    end else if (x < SatMin) begin
      r = {1'b1, OutMin};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [W:0] div_fin(input logic neg, input logic ovr,
                                         input logic [QB-1:0] q);
    logic [W:0] r;
    logic [QB-1:0] nq;
    nq = -q;
    if (ovr) begin
      r = {1'b1, (neg ? OutMin : OutMax)};
    end else if (neg) begin
      if (q > QB'(OutMin)) begin
        r = {1'b1, OutMin};
      end else begin
        r = {1'b0, nq[W-1:0]};
      end
    end else if (q > QB'(OutMax)) begin
      r = {1'b1, OutMax};
    end else begin
      r = {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  logic adv;
  ctrl_t ctrl_in;
  ctrl_t ctrl2;
  logic signed [VW-1:0] re2, im2;
  logic [DW-1:0] den2;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign ctrl_in    = '{valid: in_valid_i, op: op_e'(operation_i)};

  cau_prod #(.W(W)) u_prod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctrl_i (ctrl_in),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .ctrl_o (ctrl2),
    .re_o   (re2),
    .im_o   (im2),
    .den_o  (den2)
  );

  // Rounding, saturation of the non-divide results and divider setup.
  logic signed [VW-1:0] mre, mim;
  logic signed [RW-1:0] nre, nim;
  logic [RW-1:0] mag_re, mag_im, lim;
  logic [W:0] sre, sim;
  logic ovr_re, ovr_im, neg_re, neg_im, den_zero;
  logic [SW-1:0] side_d, side_q;
  logic [RW-1:0] rem_re_d, rem_im_d, rem_re_q, rem_im_q;
  logic [DW-1:0] den3_q;
  ctrl_t ctrl3_q;

  always_comb begin
    mre      = re2 >>> F;
    mim      = im2 >>> F;
    nre      = RW'(re2) <<< F;
    nim      = RW'(im2) <<< F;
    neg_re   = re2[VW-1];
    neg_im   = im2[VW-1];
    mag_re   = neg_re ? $unsigned(-nre) : $unsigned(nre);
    mag_im   = neg_im ? $unsigned(-nim) : $unsigned(nim);
    lim      = RW'(den2) << QB;
    ovr_re   = mag_re >= lim;
    ovr_im   = mag_im >= lim;
    den_zero = den2 == '0;
    if (ctrl2.op == OpMul) begin
      sre = sat_val(mre);
      sim = sat_val(mim);
    end else begin
      sre = sat_val(re2);
      sim = sat_val(im2);
    end
    rem_re_d = '0;
    rem_im_d = '0;
    if (ctrl2.op == OpDiv) begin
      if (den_zero) begin
        side_d = '0;
        side_d[PosDz] = 1'b1;
      end else begin
        side_d = '0;
        side_d[PosDiv]  = 1'b1;
        side_d[PosNegR] = neg_re;
        side_d[PosNegI] = neg_im;
        side_d[PosOvrR] = ovr_re;
        side_d[PosOvrI] = ovr_im;
        rem_re_d = ovr_re ? '0 : mag_re;
        rem_im_d = ovr_im ? '0 : mag_im;
      end
    end else begin
      side_d = {2'b00, sre[W] | sim[W], 4'b0000, sre[W-1:0], sim[W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl3_q <= '0;
    end else if (adv) begin
      ctrl3_q <= ctrl2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q   <= side_d;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      den3_q   <= den2;
    end
  end

  // Divider pipeline: one quotient bit per stage, most significant first.
  ctrl_t ctrl_s [QB+1];
  logic [RW-1:0] rem_re_s [QB+1];
  logic [RW-1:0] rem_im_s [QB+1];
  logic [QB-1:0] q_re_s [QB+1];
  logic [QB-1:0] q_im_s [QB+1];
  logic [DW-1:0] den_s [QB+1];
  logic [SW-1:0] side_s [QB+1];

  assign ctrl_s[0]   = ctrl3_q;
  assign rem_re_s[0] = rem_re_q;
  assign rem_im_s[0] = rem_im_q;
  assign q_re_s[0]   = '0;
  assign q_im_s[0]   = '0;
  assign den_s[0]    = den3_q;
  assign side_s[0]   = side_q;

  for (genvar k = 0; k < QB; k++) begin : g_div
    cau_div_step #(
      .RW (RW),
      .DW (DW),
      .QB (QB),
      .SH (QB - 1 - k),
      .SW (SW)
    ) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .ctrl_i   (ctrl_s[k]),
      .rem_re_i (rem_re_s[k]),
      .rem_im_i (rem_im_s[k]),
      .q_re_i   (q_re_s[k]),
      .q_im_i   (q_im_s[k]),
      .den_i    (den_s[k]),
      .side_i   (side_s[k]),
      .ctrl_o   (ctrl_s[k+1]),
      .rem_re_o (rem_re_s[k+1]),
      .rem_im_o (rem_im_s[k+1]),
      .q_re_o   (q_re_s[k+1]),
      .q_im_o   (q_im_s[k+1]),
      .den_o    (den_s[k+1]),
      .side_o   (side_s[k+1])
    );
  end

  // Sign restore, saturation of the quotients and output register.
  logic [SW-1:0] sf;
  logic [W:0] fre, fim;
  logic [W-1:0] res_re_d, res_im_d, res_re_q, res_im_q;
  logic ovf_d, dz_d, ovf_q, dz_q, out_valid_q;

  assign sf = side_s[QB];

  always_comb begin
    fre = div_fin(sf[PosNegR], sf[PosOvrR], q_re_s[QB]);
    fim = div_fin(sf[PosNegI], sf[PosOvrI], q_im_s[QB]);
    dz_d = sf[PosDz];
    if (sf[PosDiv]) begin
      res_re_d = fre[W-1:0];
      res_im_d = fim[W-1:0];
      ovf_d    = fre[W] | fim[W];
    end else begin
      res_re_d = sf[PosRe +: W];
      res_im_d = sf[PosIm +: W];
      ovf_d    = sf[PosOvf];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctrl_s[QB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      ovf_q    <= ovf_d;
      dz_q     <= dz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign div_zero_o  = dz_q;
  assign overflow_o  = ovf_q;

`include "complex_arithmetic_unit_core_assert.svh"

  `CAU_ASSERT_IMP(a_div_zero_clean, out_valid_o && div_zero_o, res_re_o == '0 && res_im_o == '0 && !overflow_o, "divide by zero gave a nonzero result or overflow")
  `CAU_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_re_o) && $stable(res_im_o), "stalled result changed")
  `CAU_ASSERT_IMP(a_ready_only_when_stalled, !in_ready_o, out_valid_o && !out_ready_i, "pipeline stalled without a waiting result")

endmodule

`default_nettype wire
